// ===== hw/rtl/spq_pkg.sv =====
// Package: shared codes and entry type for the sorted priority queue.
`default_nettype none

package spq_pkg;

   localparam int VALUE_W    = 32;
   localparam int PRIO_W     = 16;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int TOTAL_W    = 5;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [PRIO_W-1:0]  prio;
      logic signed [VALUE_W-1:0] value;
   } spq_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level: bounded min-first priority queue on a ring-buffer memory.
//
//   channel | dir | handshake             | beat contents
//   --------+-----+-----------------------+------------------------------------
//   req     | in  | req_valid / req_stall | func, item_value, item_priority
//   rsp     | out | rsp_valid / rsp_stall | front_value, status, entry_total,
//           |     |                       | is_empty
//
// Push moves each stored entry with priority >= the new one up one slot,
// one per cycle through the single write port and one comparator; pop
// and peek read the head entry first; push into an empty queue, full,
// empty and code 3 go straight to the result. Reset is synchronous, active
// high; no clearing pass is needed. A result waiting under rsp_stall does
// not block accepting the next request; that request finishes into the
// output register once it frees.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [FUNC_W-1:0]         req_func,
   input  wire  signed [VALUE_W-1:0] req_item_value,
   input  wire  signed [PRIO_W-1:0]  req_item_priority,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_front_value,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [TOTAL_W-1:0]        rsp_entry_total,
   output logic                      rsp_is_empty
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [AW:0]   DEPTH_WIDE = (AW+1)'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Ring pointer helpers (physical slot, wraps at QUEUE_DEPTH).
   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      ptr_dec = (p == '0) ? LAST_ADDR : p - 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

   // Entry storage: one write port, one registered read port.
   spq_entry_type mem [QUEUE_DEPTH];
   spq_entry_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   spq_entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control and payload registers.
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        scan_ptr_ff, scan_ptr_in;   // slot under compare
   logic [AW-1:0]        hole_ptr_ff, hole_ptr_in;   // free slot above it
   logic [AW-1:0]        scan_left_ff, scan_left_in; // logical index of scan slot
   logic                 pop_ff, pop_in;
   spq_entry_type        item_ff, item_in;
   logic signed [VALUE_W-1:0] pend_value_ff, pend_value_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic          req_beat;
   logic          rsp_free;
   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail_ptr;
   logic          prio_ge;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Slot one past the last entry.
   assign tail_sum = (AW+1)'(head_ff) + (AW+1)'(count_ff);
   assign tail_ptr = (tail_sum >= DEPTH_WIDE) ? AW'(tail_sum - DEPTH_WIDE)
                                              : AW'(tail_sum);

   // The shared comparator: does the stored entry go behind the new one?
   assign prio_ge = ($signed(rd_data_ff.prio) >= $signed(item_ff.prio));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      scan_ptr_in    = scan_ptr_ff;
      hole_ptr_in    = hole_ptr_ff;
      scan_left_in   = scan_left_ff;
      pop_in         = pop_ff;
      item_in        = item_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_empty_in   = rsp_empty_ff;
      rd_addr        = head_ff;
      wr_en          = 1'b0;
      wr_addr        = hole_ptr_ff;
      wr_data        = item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               item_in.value  = req_item_value;
               item_in.prio   = req_item_priority;
               pend_value_in  = '0;
               pend_status_in = STATUS_OK;
               pop_in         = (req_func == FUNC_POP);
               state_in       = ST_DONE;
               unique case (req_func) inside
                  FUNC_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        pend_status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = tail_ptr;
                        wr_data.value = req_item_value;
                        wr_data.prio  = req_item_priority;
                        count_in      = count_ff + 1'b1;
                     end else begin
                        hole_ptr_in  = tail_ptr;
                        scan_ptr_in  = ptr_dec(tail_ptr);
                        scan_left_in = AW'(count_ff - 1'b1);
                        rd_addr      = ptr_dec(tail_ptr);
                        state_in     = ST_SCAN;
                     end
                  end
                  FUNC_POP, FUNC_PEEK: begin
                     if (count_ff == '0) begin
                        pend_status_in = STATUS_EMPTY;
                     end else begin
                        rd_addr  = head_ff;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     // unused code: no-op, ok status
                  end
               endcase
            end
         end

         ST_SCAN: begin
            rd_addr = ptr_dec(scan_ptr_ff);
            wr_en   = 1'b1;
            if (prio_ge) begin
               // move stored entry up one slot
               wr_data     = rd_data_ff;
               hole_ptr_in = scan_ptr_ff;
               if (scan_left_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  scan_ptr_in  = ptr_dec(scan_ptr_ff);
                  scan_left_in = scan_left_ff - 1'b1;
               end
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = ST_DONE;
         end

         ST_FETCH: begin
            pend_value_in = rd_data_ff.value;
            if (pop_ff) begin
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_status_in = pend_status_ff;
               rsp_total_in  = TOTAL_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff    <= scan_ptr_in;
      hole_ptr_ff    <= hole_ptr_in;
      scan_left_ff   <= scan_left_in;
      pop_ff         <= pop_in;
      item_ff        <= item_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_empty_ff   <= rsp_empty_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
// Checker: port-level properties of the sorted priority queue, plus its bind.
`default_nettype none

module spq_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_stall,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input wire  signed [VALUE_W-1:0] rsp_front_value,
   input wire  [STATUS_W-1:0]       rsp_status,
   input wire  [TOTAL_W-1:0]        rsp_entry_total,
   input wire                       rsp_is_empty
);

   logic req_beat;
   logic rsp_beat;
   logic [1:0] outstanding_ff;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // requests accepted whose result beat has not gone out yet
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_beat) - 2'(rsp_beat);
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("queue took a request and was not busy next cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_front_value)
         && $stable(rsp_status) && $stable(rsp_entry_total))
      else $error("stalled result beat changed or dropped");

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0 && outstanding_ff != 2'd3)
      else $error("result beat without a request behind it");

   a_full_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_entry_total == TOTAL_W'(QUEUE_DEPTH) && !rsp_is_empty
         && rsp_front_value == '0)
      else $error("full status with inconsistent count or value");

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

`default_nettype wire

// ===== tb/tb_sorted_priority_queue.sv =====
// Testbench for the sorted priority queue: random and directed beats checked against a mirror.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_BEATS   = 1680;
   localparam int QUIET_LIMIT    = 2000;  // cycles with no beat on either channel before giving up
   localparam int TAIL_CYCLES    = 40;    // quiet tail after all results are taken
   localparam int IDLE_PCT       = 34;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic signed [VALUE_W-1:0] front_value;
      logic [STATUS_W-1:0]       status;
      logic [TOTAL_W-1:0]        entry_total;
      logic                      is_empty;
   } pq_result_type;

   // Mirror of the queue contents plus the results still owed by the block.
   class pq_scoreboard;
      logic signed [VALUE_W-1:0] value_slot[DEPTH];
      logic signed [PRIO_W-1:0]  prio_slot[DEPTH];
      int                        held;
      pq_result_type             owed_results[$];
      int                        fail_count;

      function new();
         held       = 0;
         fail_count = 0;
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      // Apply one accepted request to the mirror and queue its result.
      function void note_request(logic [FUNC_W-1:0] func,
                                 logic signed [VALUE_W-1:0] value,
                                 logic signed [PRIO_W-1:0] prio);
         pq_result_type r;
         int            pos;
         r.front_value = '0;
         r.status      = STATUS_OK;
         case (func) inside
            FUNC_PUSH: begin
               if (held >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  // insert ahead of the first entry with priority >= new one
                  pos = held;
                  for (int i = 0; i < held; i++) begin
                     if (prio_slot[i] >= prio) begin
                        pos = i;
                        break;
                     end
                  end
                  for (int i = held; i > pos; i--) begin
                     value_slot[i] = value_slot[i-1];
                     prio_slot[i]  = prio_slot[i-1];
                  end
                  value_slot[pos] = value;
                  prio_slot[pos]  = prio;
                  held++;
               end
            end
            FUNC_POP, FUNC_PEEK: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.front_value = value_slot[0];
                  if (func == FUNC_POP) begin
                     for (int i = 1; i < held; i++) begin
                        value_slot[i-1] = value_slot[i];
                        prio_slot[i-1]  = prio_slot[i];
                     end
                     held--;
                  end
               end
            end
            default: ;
         endcase
         r.entry_total = held[TOTAL_W-1:0];
         r.is_empty    = (held == 0);
         owed_results.push_back(r);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] front_value,
                                 logic [STATUS_W-1:0] status,
                                 logic [TOTAL_W-1:0] entry_total,
                                 logic is_empty);
         pq_result_type e;
         if (owed_results.size() == 0) begin
            $error("rsp beat with no request outstanding");
            fail_count++;
            return;
         end
         e = owed_results.pop_front();
         if (front_value !== e.front_value) begin
            $error("front_value: expected %0d, got %0d", e.front_value, front_value);
            fail_count++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            fail_count++;
         end
         if (entry_total !== e.entry_total) begin
            $error("entry_total: expected %0d, got %0d", e.entry_total, entry_total);
            fail_count++;
         end
         if (is_empty !== e.is_empty) begin
            $error("is_empty: expected %0d, got %0d", e.is_empty, is_empty);
            fail_count++;
         end
      endfunction
   endclass

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic [FUNC_W-1:0]         req_func          = FUNC_PEEK;
   logic signed [VALUE_W-1:0] req_item_value    = '0;
   logic signed [PRIO_W-1:0]  req_item_priority = '0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic signed [VALUE_W-1:0] rsp_front_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [TOTAL_W-1:0]        rsp_entry_total;
   logic                      rsp_is_empty;

   // steady: no sender gaps and no receiver stalls while set
   logic                      steady = 1'b0;
   pq_scoreboard              sb;

   sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_front_value   (rsp_front_value),
      .rsp_status        (rsp_status),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_is_empty      (rsp_is_empty)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure, changed on the falling edge only.
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   // Beat monitors. The result is checked before the request on the same edge:
   // a result can never belong to a request accepted at that very edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_front_value, rsp_status, rsp_entry_total, rsp_is_empty);
         if (req_valid && !req_stall)
            sb.note_request(req_func, req_item_value, req_item_priority);
      end
   end

   // Watchdog: a run of cycles with no beat on either channel means a hang.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the accept.
   task automatic send_request(logic [FUNC_W-1:0] func,
                               logic signed [VALUE_W-1:0] value,
                               logic signed [PRIO_W-1:0] prio);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_item_value    <= value;
      req_item_priority <= prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender off until every owed result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(15) == 0) begin
         case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // Narrow mode piles up equal priorities so tie ordering gets exercised.
   function automatic logic signed [PRIO_W-1:0] pick_prio(bit narrow);
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(19) == 0)
         return raw[0] ? 16'sh7fff : 16'sh8000;
      if (narrow)
         return $signed(16'($urandom_range(6))) - 16'sd3;
      return raw[PRIO_W-1:0];
   endfunction

   initial begin
      int                push_pct;
      bit                narrow;
      logic [FUNC_W-1:0] func;
      int                pick;

      sb = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // empty queue: pop and peek are refused, unused code does nothing
      send_request(FUNC_POP,    32'sd5, 16'sd5);
      send_request(FUNC_PEEK,   32'sd6, 16'sd6);
      send_request(FUNC_UNUSED, '1,     '1);
      // value and priority extremes; equal priorities serve newest first
      send_request(FUNC_PUSH, 32'sh7fff_ffff, 16'sd0);
      send_request(FUNC_PUSH, 32'sh8000_0000, 16'sh7fff);
      send_request(FUNC_PUSH, 32'sd0,         16'sh8000);
      send_request(FUNC_PEEK, '0, '0);
      send_request(FUNC_PUSH, -32'sd1,        16'sd0);
      send_request(FUNC_POP,  '1, '1);
      // fill up with ever lower priorities: each push lands in front of all
      for (int i = 0; i < DEPTH - 3; i++)
         send_request(FUNC_PUSH, 32'sh1000 + i, -16'sd1 - 16'(i * 2500));
      send_request(FUNC_PUSH,   32'sh5555_aaaa, 16'sh1234); // full: refused
      send_request(FUNC_PEEK,   '0, '0);
      send_request(FUNC_UNUSED, '0, '0);
      send_request(FUNC_POP,    '0, '0);
      wait_drained();

      // ---- random ----
      push_pct = 50;
      narrow   = 1'b0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 60 == 0) begin
            // swing between filling and draining so full and empty both recur
            case ($urandom_range(2))
               0:       push_pct = 80;
               1:       push_pct = 50;
               default: push_pct = 25;
            endcase
            narrow = bit'($urandom_range(1));
         end
         if (n == 700) steady = 1'b1;
         if (n == 1000) steady = 1'b0;
         if (n > 0 && n % 400 == 0) wait_drained();

         if ($urandom_range(99) < push_pct) begin
            func = FUNC_PUSH;
         end else begin
            pick = $urandom_range(99);
            if (pick < 60)      func = FUNC_POP;
            else if (pick < 95) func = FUNC_PEEK;
            else                func = FUNC_UNUSED;
         end
         send_request(func, pick_value(), pick_prio(narrow));
      end

      // ---- wind-down ----
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
